/* src/clr_pkg.sv */
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the clipped line rasterizer: channel payloads,
// the segment descriptor passed from front to back, and register indexes.
// ----------------------------------------------------------------------------
package clr_pkg;

   localparam int COORD_W    = 6;
   localparam int SYMBOL_W   = 8;
   localparam int GRID_W     = 7;
   localparam int ERR_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
      logic [COORD_W-1:0]  end_x;
      logic [COORD_W-1:0]  end_y;
      logic [SYMBOL_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  plot_x;
      logic [COORD_W-1:0]  plot_y;
      logic [SYMBOL_W-1:0] plot_symbol;
      logic                in_grid;
      logic                last_point;
   } rsp_type;

   // one classified segment, ready to walk
   typedef struct packed {
      logic [COORD_W-1:0]     cur_x;
      logic [COORD_W-1:0]     cur_y;
      logic [COORD_W-1:0]     goal_x;
      logic [COORD_W-1:0]     goal_y;
      logic [COORD_W-1:0]     span_x;
      logic [COORD_W-1:0]     span_y;
      logic                   dir_x_negative;
      logic                   dir_y_negative;
      logic signed [ERR_W-1:0] step_error;
      logic [SYMBOL_W-1:0]    held_symbol;
   } seg_type;

endpackage

/* src/clr_front.sv */
// ----------------------------------------------------------------------------
// clr_front
// Accepts segments, works out spans, step directions and the starting error,
// and holds the descriptor until the queue takes it.
// ----------------------------------------------------------------------------
module clr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  clr_pkg::req_type req_data,
   output logic             seg_valid,
   input  logic             seg_ready,
   output clr_pkg::seg_type seg_data
);

   logic             valid_ff, valid_in;
   clr_pkg::seg_type seg_ff, seg_in;
   logic             load;
   logic             x_fwd, y_fwd;
   logic [clr_pkg::COORD_W-1:0] span_x, span_y;

   assign req_ready = !valid_ff || seg_ready;
   assign load      = req_valid && req_ready;

   always_comb begin
      x_fwd  = req_data.start_x < req_data.end_x;
      y_fwd  = req_data.start_y < req_data.end_y;
      span_x = x_fwd ? (req_data.end_x - req_data.start_x)
                     : (req_data.start_x - req_data.end_x);
      span_y = y_fwd ? (req_data.end_y - req_data.start_y)
                     : (req_data.start_y - req_data.end_y);

      seg_in                = seg_ff;
      seg_in.cur_x          = req_data.start_x;
      seg_in.cur_y          = req_data.start_y;
      seg_in.goal_x         = req_data.end_x;
      seg_in.goal_y         = req_data.end_y;
      seg_in.span_x         = span_x;
      seg_in.span_y         = span_y;
      seg_in.dir_x_negative = !x_fwd;
      seg_in.dir_y_negative = !y_fwd;
      seg_in.step_error     = $signed({2'b00, span_x}) - $signed({2'b00, span_y});
      seg_in.held_symbol    = req_data.symbol;

      if (load) begin
         valid_in = 1'b1;
      end else if (seg_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         seg_ff <= seg_in;
      end
   end

   assign seg_valid = valid_ff;
   assign seg_data  = seg_ff;

endmodule

/* src/clr_queue.sv */
// ----------------------------------------------------------------------------
// clr_queue
// Short segment queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module clr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  clr_pkg::seg_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output clr_pkg::seg_type pop_data
);

   localparam int PTR_W = $clog2(clr_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(clr_pkg::QUEUE_DEPTH + 1);

   clr_pkg::seg_type entry_ff [clr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(clr_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(clr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(clr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/clr_back.sv */
// ----------------------------------------------------------------------------
// clr_back
// Bresenham walker: takes one segment from the queue and emits into an output
// register one point per cycle unless stalled, with grid clipping, end marker.
// ----------------------------------------------------------------------------
module clr_back #(
   parameter int MAX_DIM = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             seg_valid,
   output logic                             seg_ready,
   input  clr_pkg::seg_type                 seg_data,
   input  logic                             csr_we,
   input  logic [clr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [clr_pkg::GRID_W-1:0]       csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output clr_pkg::rsp_type                 rsp_data
);

   localparam int LIMIT = (MAX_DIM < 64) ? MAX_DIM : 64;
   localparam int CNT_W = $clog2(LIMIT);

   logic                         busy_ff, busy_in;
   clr_pkg::seg_type             seg_ff, seg_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   clr_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [clr_pkg::GRID_W-1:0]   grid_w_ff, grid_h_ff;

   logic                         emit, take, at_end, last;
   logic                         move_x, move_y;
   logic signed [clr_pkg::ERR_W:0] e2, dx, dy;
   logic signed [clr_pkg::ERR_W-1:0] err_next;

   assign seg_ready = !busy_ff;
   assign take      = seg_valid && seg_ready;
   assign emit      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign at_end    = (seg_ff.cur_x == seg_ff.goal_x) && (seg_ff.cur_y == seg_ff.goal_y);
   assign last      = at_end || (cnt_ff == CNT_W'(LIMIT - 1));

   always_comb begin
      e2     = {seg_ff.step_error, 1'b0};
      dx     = $signed({3'b000, seg_ff.span_x});
      dy     = $signed({3'b000, seg_ff.span_y});
      move_x = e2 > -dy;
      move_y = e2 < dx;
      err_next = seg_ff.step_error
               - (move_x ? $signed({2'b00, seg_ff.span_y}) : $signed(8'sd0))
               + (move_y ? $signed({2'b00, seg_ff.span_x}) : $signed(8'sd0));

      rsp_data_in.plot_x      = seg_ff.cur_x;
      rsp_data_in.plot_y      = seg_ff.cur_y;
      rsp_data_in.plot_symbol = seg_ff.held_symbol;
      rsp_data_in.in_grid     = ({1'b0, seg_ff.cur_x} < grid_w_ff)
                             && ({1'b0, seg_ff.cur_y} < grid_h_ff);
      rsp_data_in.last_point  = last;

      seg_in  = seg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (take) begin
         seg_in  = seg_data;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (emit) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            seg_in.step_error = err_next;
            if (move_x) begin
               seg_in.cur_x = seg_ff.dir_x_negative ? seg_ff.cur_x - 1'b1
                                                    : seg_ff.cur_x + 1'b1;
            end
            if (move_y) begin
               seg_in.cur_y = seg_ff.dir_y_negative ? seg_ff.cur_y - 1'b1
                                                    : seg_ff.cur_y + 1'b1;
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grid_w_ff    <= clr_pkg::GRID_RESET;
         grid_h_ff    <= clr_pkg::GRID_RESET;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               clr_pkg::CSR_GRID_WIDTH: begin
                  grid_w_ff <= csr_wdata;
               end
               clr_pkg::CSR_GRID_HEIGHT: begin
                  grid_h_ff <= csr_wdata;
               end
               default: begin
                  // unmapped index, write dropped
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
      cnt_ff <= cnt_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> !busy_ff)
      else $error("walker still busy after emitting last point");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !take)
      else $error("segment taken while walking");

   a_walk_stays_busy: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !(emit && last)) |=> busy_ff)
      else $error("walker dropped a segment before its last point");

   a_out_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_valid_ff && !rsp_ready) |=> $stable(seg_ff.cur_x) && $stable(cnt_ff))
      else $error("walker advanced while output stalled");
`endif

endmodule

/* src/clipped_line_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_unit
// Line segment rasterizer: walks each segment with the all-octant Bresenham
// rule and emits one clipped point per cycle while walking, unless rsp_ready stalls it.
//
//   channel  direction  handshake       payload
//   req_     in         valid/ready     clr_pkg::req_type (one segment)
//   rsp_     out        valid/ready     clr_pkg::rsp_type (one point)
//   csr_     in         write enable    grid_width / grid_height
//
// the walker loads a segment from the queue and then emits its points, one
// per cycle unless stalled, before it can load the next segment
// the front classifies the next segment and the queue holds two more while
// the walker runs; a stalled rsp_ready freezes the walker in place
// reset is synchronous and clears all control state, grid size back to 64
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_unit #(
   parameter int MAX_DIM = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  clr_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output clr_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [clr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [clr_pkg::GRID_W-1:0]     csr_wdata
);

   logic             front_valid, front_ready;
   clr_pkg::seg_type front_seg;
   logic             queue_valid, back_ready;
   clr_pkg::seg_type queue_seg;

   clr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .seg_valid (front_valid),
      .seg_ready (front_ready),
      .seg_data  (front_seg)
   );

   clr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_seg),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_data   (queue_seg)
   );

   clr_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (queue_valid),
      .seg_ready (back_ready),
      .seg_data  (queue_seg),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
